// File: sv/simplified_des_block_cipher_core_defines.svh
// ----------------------------------------------------------------------------
// Simplified DES core: assertion macros
// Shared assertion shorthands, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SIMPLIFIED_DES_BLOCK_CIPHER_CORE_DEFINES_SVH
`define SIMPLIFIED_DES_BLOCK_CIPHER_CORE_DEFINES_SVH

// same-cycle implication
`define SDES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sdes_pkg.sv
// ----------------------------------------------------------------------------
// sdes_pkg
// Types, tables and round function of the two-round simplified DES cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdes_pkg;

  localparam int unsigned BLK_W = 8;
  localparam int unsigned HALF_W = 4;
  localparam int unsigned KEY_W = 8;

  localparam logic [KEY_W-1:0] FIRST_KEY_RST = 8'd170;
  localparam logic [KEY_W-1:0] SECOND_KEY_RST = 8'd85;

  // configuration register indexes
  localparam logic REG_FIRST_KEY = 1'b0;
  localparam logic REG_SECOND_KEY = 1'b1;

  // S-boxes flattened as {row, col}
  localparam logic [1:0] S0_TAB [0:15] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };
  localparam logic [1:0] S1_TAB [0:15] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  // halves travelling down the pipe; decrypt runs with the halves swapped
  typedef struct packed {
    logic              enc;
    logic [HALF_W-1:0] a;
    logic [HALF_W-1:0] b;
  } stage_t;

  // table position 1 is the MSB
  function automatic logic [BLK_W-1:0] perm_ip(input logic [BLK_W-1:0] v);
    return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
  endfunction

  function automatic logic [BLK_W-1:0] perm_fp(input logic [BLK_W-1:0] v);
    return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
  endfunction

  function automatic logic [KEY_W-1:0] expand(input logic [HALF_W-1:0] h);
    return {h[0], h[3], h[2], h[1], h[2], h[1], h[0], h[3]};
  endfunction

  function automatic logic [HALF_W-1:0] perm_p4(input logic [HALF_W-1:0] s);
    return {s[2], s[0], s[1], s[3]};
  endfunction

  function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] h,
                                                input logic [KEY_W-1:0]  key);
    logic [KEY_W-1:0]  x;
    logic [1:0]        s0;
    logic [1:0]        s1;
    x  = expand(h) ^ key;
    s0 = S0_TAB[{x[7], x[4], x[6:5]}];
    s1 = S1_TAB[{x[3], x[0], x[2:1]}];
    return perm_p4({s0, s1});
  endfunction

endpackage

`default_nettype wire

// File: sv/sdes_if.sv
// ----------------------------------------------------------------------------
// sdes_in_if / sdes_out_if
// Valid/ready channels carrying cipher requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdes_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_in;

  modport source (output valid, output func, output data_in, input ready);
  modport sink (input valid, input func, input data_in, output ready);
endinterface

interface sdes_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

`default_nettype wire

// File: sv/sdes_round.sv
// ----------------------------------------------------------------------------
// sdes_round
// One Feistel round as a registered pipeline stage with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdes_round
  import sdes_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire stage_t           up_st,
  input  wire logic [KEY_W-1:0] key,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output stage_t                dn_st
);

  logic   vld_r;
  stage_t st_r;
  stage_t st_nxt;

  // take a new transfer when empty or when the held one leaves
  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    st_nxt.enc = up_st.enc;
    st_nxt.a   = up_st.b;
    st_nxt.b   = up_st.a ^ round_f(up_st.b, key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      st_r <= st_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_st    = st_r;

endmodule

`default_nettype wire

// File: sv/simplified_des_block_cipher_core.sv
// An input transfer passes through four registered stages (IP, round 1, round 2, FP) to the result.
// Throughput: one block per cycle while the output is not stalled; each stage
// advances whenever the next one frees up. A stalled output holds its block
// while the stages behind it keep filling. Reset (synchronous, rst_n low)
// empties every stage and loads the round keys with 170 and 85.
// ----------------------------------------------------------------------------
// simplified_des_block_cipher_core
// Four-stage pipelined two-round simplified DES with configurable round keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "simplified_des_block_cipher_core_defines.svh"

module simplified_des_block_cipher_core
  import sdes_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  sdes_in_if.sink               in_ch,
  sdes_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic             cfg_idx,
  input  wire logic [KEY_W-1:0] cfg_wdata
);

  logic [KEY_W-1:0] key1_r;
  logic [KEY_W-1:0] key2_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key1_r <= FIRST_KEY_RST;
      key2_r <= SECOND_KEY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FIRST_KEY:  key1_r <= cfg_wdata;
        REG_SECOND_KEY: key2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: initial permutation, swap halves for decrypt
  logic             ip_vld_r;
  stage_t           ip_st_r;
  stage_t           ip_st_nxt;
  logic             ip_ready;
  logic [BLK_W-1:0] ip_blk;

  logic   r1_up_ready;
  logic   r1_vld;
  stage_t r1_st;
  logic   r2_up_ready;
  logic   r2_vld;
  stage_t r2_st;

  assign ip_ready    = !ip_vld_r || r1_up_ready;
  assign in_ch.ready = ip_ready;
  assign ip_blk      = perm_ip(in_ch.data_in);

  always_comb begin
    ip_st_nxt.enc = in_ch.func;
    if (in_ch.func) begin
      ip_st_nxt.a = ip_blk[7:4];
      ip_st_nxt.b = ip_blk[3:0];
    end else begin
      ip_st_nxt.a = ip_blk[3:0];
      ip_st_nxt.b = ip_blk[7:4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_vld_r <= 1'b0;
    end else if (ip_ready) begin
      ip_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ip_ready && in_ch.valid) begin
      ip_st_r <= ip_st_nxt;
    end
  end

  // rounds: decrypt takes the keys in reverse order
  logic [KEY_W-1:0] r1_key;
  logic [KEY_W-1:0] r2_key;

  assign r1_key = ip_st_r.enc ? key1_r : key2_r;
  assign r2_key = r1_st.enc ? key2_r : key1_r;

  logic fp_ready;

  sdes_round u_round1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ip_vld_r),
    .up_ready (r1_up_ready),
    .up_st    (ip_st_r),
    .key      (r1_key),
    .dn_valid (r1_vld),
    .dn_ready (r2_up_ready),
    .dn_st    (r1_st)
  );

  sdes_round u_round2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (r1_vld),
    .up_ready (r2_up_ready),
    .up_st    (r1_st),
    .key      (r2_key),
    .dn_valid (r2_vld),
    .dn_ready (fp_ready),
    .dn_st    (r2_st)
  );

  // stage 4: undo the decrypt swap, final permutation, output register
  logic             out_vld_r;
  logic [BLK_W-1:0] out_data_r;
  logic [BLK_W-1:0] out_data_nxt;

  assign fp_ready     = !out_vld_r || out_ch.ready;
  assign out_data_nxt = r2_st.enc ? perm_fp({r2_st.a, r2_st.b})
                                  : perm_fp({r2_st.b, r2_st.a});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fp_ready) begin
      out_vld_r <= r2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fp_ready && r2_vld) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.data_out = out_data_r;

  // back-pressure reaches the input only when every stage is occupied
  `SDES_ASSERT_NOW(a_full_stall, !in_ch.ready,
    ip_vld_r && r1_vld && r2_vld && out_vld_r, "input stalled with a free stage")
  // a block held behind a stalled stage keeps its halves
  `SDES_ASSERT_NEXT(a_r2_hold, r2_vld && !fp_ready,
    r2_vld && $stable(r2_st), "round 2 block lost or changed under stall")
  // a block leaving round 2 into a free output stage shows up at the output
  `SDES_ASSERT_NEXT(a_out_fill, r2_vld && fp_ready,
    out_vld_r, "round 2 block dropped at the output stage")

endmodule

`default_nettype wire
